>>> sv/jbt_pkg.sv
// ============================================================================
// jbt_pkg
// Shared constants and types for the JSON byte tokenizer: character codes,
// lexer mode codes, result entry layout and the push bundle that goes from
// the lexer to the result queue.
// ============================================================================
package jbt_pkg;

   // Character codes the lexer reacts to.
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_QUOTE     = 8'h22;
   localparam logic [7:0] CHAR_LBRACKET  = 8'h5B;
   localparam logic [7:0] CHAR_RBRACKET  = 8'h5D;
   localparam logic [7:0] CHAR_LBRACE    = 8'h7B;
   localparam logic [7:0] CHAR_RBRACE    = 8'h7D;
   localparam logic [7:0] CHAR_COMMA     = 8'h2C;
   localparam logic [7:0] CHAR_COLON     = 8'h3A;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_TAB       = 8'h09;
   localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;

   // Lexer mode codes.
   localparam logic [1:0] MODE_BODY       = 2'd0;
   localparam logic [1:0] MODE_STRING     = 2'd1;
   localparam logic [1:0] MODE_ESC_BODY   = 2'd2;
   localparam logic [1:0] MODE_ESC_STRING = 2'd3;

   // Default depth of the result queue; at least three keeps one item a cycle while rsp_tready stays high.
   localparam int RSP_DEPTH_DEFAULT = 4;

   // One result beat.
   typedef struct packed {
      logic [7:0] out_byte;
      logic       token_end;
      logic       run_last;
   } rsp_entry_type;

   // Results of one lexer step, packed toward entry zero.
   typedef struct packed {
      logic [1:0]    count;
      rsp_entry_type entry0;
      rsp_entry_type entry1;
   } push_bundle_type;

endpackage

>>> sv/jbt_lexer.sv
// ============================================================================
// jbt_lexer
// Lexer state and one-step token logic. Holds the mode, the held-back byte
// and its valid flag, and turns one input beat into zero, one or two results.
// ============================================================================
module jbt_lexer import jbt_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            step_valid,
   input  logic [7:0]      step_byte,
   input  logic            step_eoi,
   output push_bundle_type push
);

   logic [1:0] mode_ff, mode_in;
   logic       held_valid_ff, held_valid_in;
   logic [7:0] held_byte_ff, held_byte_in;

   logic       is_struct;
   logic       is_space;
   logic       do_append;
   logic       do_close;
   logic       do_struct;
   logic       emit_held;
   logic       emit_cur;
   rsp_entry_type held_entry;
   rsp_entry_type cur_entry;

   // Character classes.
   assign is_struct = (step_byte == CHAR_LBRACKET) || (step_byte == CHAR_RBRACKET) ||
                      (step_byte == CHAR_LBRACE)   || (step_byte == CHAR_RBRACE)   ||
                      (step_byte == CHAR_COMMA)    || (step_byte == CHAR_COLON);
   assign is_space  = (step_byte == CHAR_SPACE) || (step_byte == CHAR_TAB) ||
                      (step_byte == CHAR_NEWLINE);

   // Decide the action for this byte and the next mode.
   always_comb begin
      do_append = 1'b0;
      do_close  = 1'b0;
      do_struct = 1'b0;
      mode_in   = mode_ff;
      if (step_eoi) begin
         mode_in = MODE_BODY;
      end else begin
         case (mode_ff)
            MODE_BODY: begin
               if (step_byte == CHAR_BACKSLASH) begin
                  mode_in = MODE_ESC_BODY;
               end else if (step_byte == CHAR_QUOTE) begin
                  mode_in   = MODE_STRING;
                  do_append = 1'b1;
               end else if (is_struct) begin
                  do_struct = 1'b1;
               end else if (!is_space) begin
                  do_append = 1'b1;
               end
            end
            MODE_STRING: begin
               if (step_byte == CHAR_BACKSLASH) begin
                  mode_in = MODE_ESC_STRING;
               end else if (step_byte == CHAR_QUOTE) begin
                  mode_in   = MODE_BODY;
                  do_append = 1'b1;
                  do_close  = 1'b1;
               end else begin
                  do_append = 1'b1;
               end
            end
            MODE_ESC_BODY: begin
               mode_in   = MODE_BODY;
               do_append = 1'b1;
            end
            default: begin
               mode_in   = MODE_STRING;
               do_append = 1'b1;
            end
         endcase
      end
   end

   // The held byte goes out first; it ends its token unless a byte is appended.
   assign emit_held = held_valid_ff && (do_append || do_struct || step_eoi);
   assign emit_cur  = (do_append && do_close) || do_struct;

   assign held_entry = '{out_byte: held_byte_ff, token_end: !do_append, run_last: !emit_cur};
   assign cur_entry  = '{out_byte: step_byte, token_end: 1'b1, run_last: 1'b1};

   // Pack the results toward entry zero.
   always_comb begin
      push.count  = {1'b0, emit_held} + {1'b0, emit_cur};
      push.entry0 = emit_held ? held_entry : cur_entry;
      push.entry1 = cur_entry;
      if (!step_valid) begin
         push.count = 2'd0;
      end
   end

   // Held byte update.
   always_comb begin
      held_valid_in = held_valid_ff;
      held_byte_in  = held_byte_ff;
      if (do_append) begin
         held_byte_in  = step_byte;
         held_valid_in = !do_close;
      end else if (do_struct || step_eoi) begin
         held_valid_in = 1'b0;
      end
   end

   // State registers advance only on a step.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_BODY;
         held_valid_ff <= 1'b0;
         held_byte_ff  <= 8'd0;
      end else if (step_valid) begin
         mode_ff       <= mode_in;
         held_valid_ff <= held_valid_in;
         held_byte_ff  <= held_byte_in;
      end
   end

endmodule

>>> sv/jbt_rsp_fifo.sv
// ============================================================================
// jbt_rsp_fifo
// Result queue. Takes up to two entries per cycle from the lexer and hands
// them out one beat at a time. Signals room while two entries are free.
// ============================================================================
module jbt_rsp_fifo import jbt_pkg::*; #(
   parameter int DEPTH = RSP_DEPTH_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  push_bundle_type push,
   output logic            room,
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   output rsp_entry_type   rsp_entry
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] ROOM_MAX = CNT_W'(DEPTH - 2);

   rsp_entry_type    mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [PTR_W-1:0] wr_ptr_1;
   logic [PTR_W-1:0] wr_ptr_2;
   logic [PTR_W-1:0] rd_ptr_1;
   logic             pop;

   assign pop        = rsp_tvalid && rsp_tready;
   assign rsp_tvalid = (count_ff != '0);
   assign rsp_entry  = mem_ff[rd_ptr_ff];
   assign room       = (count_ff <= ROOM_MAX);

   // Wrapping pointer increments.
   assign wr_ptr_1 = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
   assign wr_ptr_2 = (wr_ptr_1 == PTR_LAST) ? '0 : wr_ptr_1 + 1'b1;
   assign rd_ptr_1 = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;

   // Pointer and fill count next values.
   always_comb begin
      case (push.count)
         2'd1:    wr_ptr_in = wr_ptr_1;
         2'd2:    wr_ptr_in = wr_ptr_2;
         default: wr_ptr_in = wr_ptr_ff;
      endcase
      rd_ptr_in = pop ? rd_ptr_1 : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push.count) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.entry0;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_ptr_1] <= push.entry1;
      end
   end

endmodule

>>> sv/json_byte_tokenizer.sv
// ============================================================================
// json_byte_tokenizer
// Splits a JSON byte stream into tokens. Each result beat carries one token
// byte, a token-end flag and a flag on the last result of its input beat.
// ============================================================================
//
// Channel  Direction  Payload
// req_     in         tdata: in_byte[7:0]; tuser: end_of_input
// rsp_     out        tdata: out_byte[7:0]; tuser: token_end; tlast: run_last
//
// One input beat is taken per cycle while req_tready is high. A beat is
// first held in the input register, then the lexer writes its zero, one
// or two results into the result queue, which offers them on rsp_.
// The input register moves on only while the queue has two free entries,
// so a stalled output side or a run of two-result beats backs up into
// req_tready. Reset clears the lexer mode, the held byte flag and the queue.
module json_byte_tokenizer import jbt_pkg::*; #(
   parameter int RSP_DEPTH = RSP_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tuser,   // [0] end_of_input
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tuser,   // [0] token_end
   output logic       rsp_tlast
);

   logic            in_valid_ff, in_valid_in;
   logic [7:0]      in_byte_ff;
   logic            in_eoi_ff;
   logic            room;
   logic            step;
   logic            req_fire;
   push_bundle_type push;
   rsp_entry_type   rsp_entry;

   // Input register advances when the queue can take a whole step.
   assign step       = in_valid_ff && room;
   assign req_tready = !in_valid_ff || room;
   assign req_fire   = req_tvalid && req_tready;
   assign in_valid_in = req_fire || (in_valid_ff && !step);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff <= req_tdata;
         in_eoi_ff  <= req_tuser;
      end
   end

   // Token logic.
   jbt_lexer u_lexer (
      .clock      (clock),
      .reset      (reset),
      .step_valid (step),
      .step_byte  (in_byte_ff),
      .step_eoi   (in_eoi_ff),
      .push       (push)
   );

   // Result queue.
   jbt_rsp_fifo #(
      .DEPTH (RSP_DEPTH)
   ) u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .room       (room),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_entry  (rsp_entry)
   );

   assign rsp_tdata = rsp_entry.out_byte;
   assign rsp_tuser = rsp_entry.token_end;
   assign rsp_tlast = rsp_entry.run_last;

endmodule
